@@ design/fgbl_pkg.sv @@
// shared types and constants for the functional graph binary lifting block
`timescale 1ns / 1ps
`default_nettype none
package fgbl_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int STEP_BITS_DEF = 32;

  localparam int IN_W   = 80;
  localparam int OUT_W  = 16;
  localparam int VAL_W  = 12;
  localparam int CNT_W  = 11;

  typedef enum logic [1:0] {
    OPC_LOAD = 2'd0,
    OPC_KTH  = 2'd1,
    OPC_DIST = 2'd2,
    OPC_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QINIT,
    S_B_INIT,
    S_B_RD,
    S_B_J,
    S_B_W2,
    S_K_STEP,
    S_K_WAIT,
    S_D_START,
    S_D_UP,
    S_D_UPW,
    S_D_DN,
    S_D_DNW,
    S_RES
  } state_t;

  typedef enum logic [4:0] {
    DP_NONE,
    DP_LOAD,
    DP_CAPTURE,
    DP_Q_INIT,
    DP_B_INIT,
    DP_B_NEXT_LVL,
    DP_B_RD,
    DP_B_J_RD,
    DP_B_WR,
    DP_K_RD,
    DP_K_SKIP,
    DP_K_TAKE,
    DP_D_RD,
    DP_D_INC,
    DP_D_DN_RD,
    DP_D_DN_UPD,
    DP_ANS_S,
    DP_ANS_ZERO,
    DP_ANS_NEG1,
    DP_ANS_RET,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic node_ok;    // load index below MAX_NODES
    logic no_levels;  // single level, nothing to build
    logic i_done;     // build sweep reached node count
    logic lvl_last;   // level counter at top level
    logic rd_inside;  // read data is a node in use
    logic k_zero;
    logic k_lsb;
    logic s_inside;
    logic d_outside;  // start not strictly inside interval
    logic t_in;       // hop result inside interval
    logic pow_ge;     // 2^d reaches node count
    logic d_zero;
    logic out_busy;   // output register full and not taken
  } dp_status_t;

endpackage
`default_nettype wire

@@ design/fgbl_dp.sv @@
// datapath: jump table memory, walk registers and output register
`timescale 1ns / 1ps
`default_nettype none
module fgbl_dp import fgbl_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [IN_W-1:0]  in_data,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  input  wire logic             out_tready,
  output logic                  out_valid,
  output logic [OUT_W-1:0]      out_data,
  input  wire dp_cmd_t          cmd,
  output dp_status_t            st
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int LVL_W  = (STEP_BITS > 1) ? $clog2(STEP_BITS) : 1;
  localparam int ADDR_W = LVL_W + NODE_W;
  localparam int DEPTH  = 1 << ADDR_W;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data_r;

  logic [CNT_W-1:0]        node_count_r;
  logic [LVL_W-1:0]        d_r, d_nxt;
  logic [CNT_W-1:0]        i_r, i_nxt;
  logic [STEP_BITS-1:0]    k_r, k_nxt;
  logic signed [VAL_W-1:0] s_r, s_nxt;
  logic signed [VAL_W-1:0] start_r, start_nxt;
  logic signed [VAL_W-1:0] lo_r, lo_nxt;
  logic signed [VAL_W-1:0] hi_r, hi_nxt;
  logic signed [VAL_W-1:0] hsrc_r, hsrc_nxt;
  logic [VAL_W-1:0]        ret_r, ret_nxt;
  logic [VAL_W-1:0]        ans_r, ans_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]        out_data_r, out_data_nxt;

  logic [CNT_W-1:0]        nuse;
  logic                    rd_en, wr_en;
  logic [ADDR_W-1:0]       rd_addr, wr_addr;
  logic [VAL_W-1:0]        wr_data;
  logic signed [VAL_W-1:0] t_val;
  logic [VAL_W-1:0]        pow_d;

  logic [9:0]              f_node;
  logic [VAL_W-1:0]        f_succ;
  logic [31:0]             f_step;
  logic [VAL_W-1:0]        f_lo;
  logic [VAL_W-1:0]        f_hi;

  assign f_node   = in_data[11:2];
  assign f_succ   = in_data[23:12];
  assign f_step   = in_data[55:24];
  assign f_lo     = in_data[67:56];
  assign f_hi     = in_data[79:68];

  function automatic logic [NODE_W-1:0] nidx(input logic [VAL_W-1:0] v);
    return NODE_W'(v[CNT_W-1:0]);
  endfunction

  function automatic logic in_graph(input logic [VAL_W-1:0] v,
                                    input logic [CNT_W-1:0] n);
    return !v[VAL_W-1] && (v[CNT_W-1:0] < n);
  endfunction

  assign nuse  = (32'(node_count_r) > MAX_NODES) ? CNT_W'(MAX_NODES) : node_count_r;
  assign t_val = in_graph(hsrc_r, nuse) ? $signed(rd_data_r) : hsrc_r;
  assign pow_d = VAL_W'(1) << d_r;

  // status
  always_comb begin
    st.node_ok   = (32'(f_node) < MAX_NODES);
    st.no_levels = (STEP_BITS == 1);
    st.i_done    = (i_r >= nuse);
    st.lvl_last  = (32'(d_r) == STEP_BITS - 1);
    st.rd_inside = in_graph(rd_data_r, nuse);
    st.k_zero    = (k_r == '0);
    st.k_lsb     = k_r[0];
    st.s_inside  = in_graph(s_r, nuse);
    st.d_outside = (start_r <= lo_r) || (hi_r <= start_r);
    st.t_in      = (lo_r < t_val) && (t_val < hi_r);
    st.pow_ge    = (32'(d_r) < VAL_W) ? (pow_d >= VAL_W'(nuse)) : 1'b1;
    st.d_zero    = (d_r == '0);
    st.out_busy  = out_valid_r && !out_tready;
  end

  // memory port selection
  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = '0;
    wr_addr = '0;
    wr_data = rd_data_r;
    case (cmd.op)
      DP_LOAD: begin
        wr_en   = st.node_ok;
        wr_addr = {LVL_W'(0), NODE_W'(f_node)};
        wr_data = f_succ;
      end
      DP_B_RD: begin
        rd_en   = 1'b1;
        rd_addr = {LVL_W'(d_r - 1'b1), NODE_W'(i_r)};
      end
      DP_B_J_RD: begin
        rd_en   = 1'b1;
        rd_addr = {LVL_W'(d_r - 1'b1), nidx(rd_data_r)};
      end
      DP_B_WR: begin
        wr_en   = 1'b1;
        wr_addr = {d_r, NODE_W'(i_r)};
      end
      DP_K_RD: begin
        rd_en   = 1'b1;
        rd_addr = {d_r, nidx(s_r)};
      end
      DP_D_RD: begin
        rd_en   = 1'b1;
        rd_addr = {d_r, nidx(start_r)};
      end
      DP_D_DN_RD: begin
        rd_en   = 1'b1;
        rd_addr = {LVL_W'(d_r - 1'b1), nidx(s_r)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // walk registers
  always_comb begin
    d_nxt     = d_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    s_nxt     = s_r;
    start_nxt = start_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    hsrc_nxt  = hsrc_r;
    ret_nxt   = ret_r;
    ans_nxt   = ans_r;
    case (cmd.op)
      DP_CAPTURE: begin
        s_nxt     = $signed(VAL_W'(f_node));
        start_nxt = $signed(VAL_W'(f_node));
        k_nxt     = STEP_BITS'({31'd0, f_step});
        lo_nxt    = $signed(f_lo);
        hi_nxt    = $signed(f_hi);
      end
      DP_Q_INIT: begin
        d_nxt   = '0;
        ret_nxt = '0;
      end
      DP_B_INIT: begin
        d_nxt = LVL_W'(1);
        i_nxt = '0;
      end
      DP_B_NEXT_LVL: begin
        d_nxt = d_r + 1'b1;
        i_nxt = '0;
      end
      DP_B_WR:   i_nxt = i_r + 1'b1;
      DP_K_SKIP: begin
        k_nxt = k_r >> 1;
        d_nxt = d_r + 1'b1;
      end
      DP_K_TAKE: begin
        s_nxt = $signed(rd_data_r);
        k_nxt = k_r >> 1;
        d_nxt = d_r + 1'b1;
      end
      DP_D_RD:    hsrc_nxt = start_r;
      DP_D_INC:   d_nxt = d_r + 1'b1;
      DP_D_DN_RD: begin
        hsrc_nxt = s_r;
        d_nxt    = d_r - 1'b1;
      end
      DP_D_DN_UPD: begin
        if (st.t_in) begin
          ret_nxt = ret_r + pow_d;
          s_nxt   = t_val;
        end
      end
      DP_ANS_S:    ans_nxt = s_r;
      DP_ANS_ZERO: ans_nxt = '0;
      DP_ANS_NEG1: ans_nxt = '1;
      DP_ANS_RET:  ans_nxt = ret_r + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    d_r     <= d_nxt;
    i_r     <= i_nxt;
    k_r     <= k_nxt;
    s_r     <= s_nxt;
    start_r <= start_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    hsrc_r  <= hsrc_nxt;
    ret_r   <= ret_nxt;
    ans_r   <= ans_nxt;
  end

  // output register and node count
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    if (cmd.op == DP_OUT) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = ans_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      node_count_r <= CNT_W'(1024);
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        node_count_r <= cfg_wdata;
      end
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = OUT_W'(out_data_r);

  property p_one_port_op;
    @(posedge clk) disable iff (!rst_n) !(rd_en && wr_en);
  endproperty
  a_one_port_op: assert property (p_one_port_op) else $error("table read and write together");

  property p_lvl_range;
    @(posedge clk) disable iff (!rst_n) rd_en |-> (32'(rd_addr >> NODE_W) < STEP_BITS);
  endproperty
  a_lvl_range: assert property (p_lvl_range) else $error("table read beyond top level");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (cmd.op == DP_OUT) |=> (out_valid_r && out_data_r == $past(ans_r));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result not loaded");

endmodule
`default_nettype wire

@@ design/fgbl_ctrl.sv @@
// controller state machine: sequences loads, table build and query walks
`timescale 1ns / 1ps
`default_nettype none
module fgbl_ctrl import fgbl_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic [1:0] in_opcode,
  input  wire logic       cfg_we,
  output logic            in_tready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t st
);

  state_t  state_r, state_nxt;
  logic    built_r, built_nxt;
  opcode_t op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      built_r <= 1'b0;
      op_r    <= OPC_NOP;
    end else begin
      state_r <= state_nxt;
      built_r <= built_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    op_nxt    = op_r;
    in_tready = 1'b0;
    cmd.op    = DP_NONE;
    if (cfg_we) begin
      built_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          unique case (opcode_t'(in_opcode)) inside
            OPC_LOAD: begin
              cmd.op = DP_LOAD;
              if (st.node_ok) begin
                built_nxt = 1'b0;
              end
            end
            OPC_KTH, OPC_DIST: begin
              cmd.op    = DP_CAPTURE;
              op_nxt    = opcode_t'(in_opcode);
              state_nxt = built_r ? S_QINIT : S_B_INIT;
            end
            default: ;
          endcase
        end
      end
      S_B_INIT: begin
        if (st.no_levels) begin
          built_nxt = 1'b1;
          state_nxt = S_QINIT;
        end else begin
          cmd.op    = DP_B_INIT;
          state_nxt = S_B_RD;
        end
      end
      S_B_RD: begin
        if (st.i_done) begin
          if (st.lvl_last) begin
            built_nxt = 1'b1;
            state_nxt = S_QINIT;
          end else begin
            cmd.op = DP_B_NEXT_LVL;
          end
        end else begin
          cmd.op    = DP_B_RD;
          state_nxt = S_B_J;
        end
      end
      S_B_J: begin
        if (st.rd_inside) begin
          cmd.op    = DP_B_J_RD;
          state_nxt = S_B_W2;
        end else begin
          cmd.op    = DP_B_WR;
          state_nxt = S_B_RD;
        end
      end
      S_B_W2: begin
        cmd.op    = DP_B_WR;
        state_nxt = S_B_RD;
      end
      S_QINIT: begin
        cmd.op    = DP_Q_INIT;
        state_nxt = (op_r == OPC_KTH) ? S_K_STEP : S_D_START;
      end
      S_K_STEP: begin
        if (st.k_zero || !st.s_inside) begin
          cmd.op    = DP_ANS_S;
          state_nxt = S_RES;
        end else if (st.k_lsb) begin
          cmd.op    = DP_K_RD;
          state_nxt = S_K_WAIT;
        end else begin
          cmd.op = DP_K_SKIP;
        end
      end
      S_K_WAIT: begin
        cmd.op    = DP_K_TAKE;
        state_nxt = S_K_STEP;
      end
      S_D_START: begin
        if (st.d_outside) begin
          cmd.op    = DP_ANS_ZERO;
          state_nxt = S_RES;
        end else begin
          state_nxt = S_D_UP;
        end
      end
      S_D_UP: begin
        cmd.op    = DP_D_RD;
        state_nxt = S_D_UPW;
      end
      S_D_UPW: begin
        if (!st.t_in) begin
          state_nxt = S_D_DN;
        end else if (st.pow_ge || st.lvl_last) begin
          cmd.op    = DP_ANS_NEG1;
          state_nxt = S_RES;
        end else begin
          cmd.op    = DP_D_INC;
          state_nxt = S_D_UP;
        end
      end
      S_D_DN: begin
        if (st.d_zero) begin
          cmd.op    = DP_ANS_RET;
          state_nxt = S_RES;
        end else begin
          cmd.op    = DP_D_DN_RD;
          state_nxt = S_D_DNW;
        end
      end
      S_D_DNW: begin
        cmd.op    = DP_D_DN_UPD;
        state_nxt = S_D_DN;
      end
      S_RES: begin
        if (!st.out_busy) begin
          cmd.op    = DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  property p_cfg_clears;
    @(posedge clk) disable iff (!rst_n) cfg_we |=> !built_r;
  endproperty
  a_cfg_clears: assert property (p_cfg_clears) else $error("levels still marked built");

  property p_res_leaves;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_RES && !st.out_busy) |=> (state_r == S_IDLE);
  endproperty
  a_res_leaves: assert property (p_res_leaves) else $error("result stage stuck");

  property p_load_one_cycle;
    @(posedge clk) disable iff (!rst_n)
      (state_r == S_IDLE && in_tvalid && in_opcode == OPC_LOAD) |=> (state_r == S_IDLE);
  endproperty
  a_load_one_cycle: assert property (p_load_one_cycle) else $error("load left idle");

endmodule
`default_nettype wire

@@ design/functional_graph_binary_lifting.sv @@
// top level: k-th successor and interval-exit distance on a functional graph
// usage:
//  - in_ channel carries one transaction per load or query; out_ carries one
//    12-bit answer per query, loads and opcode 3 give no answer
//  - cfg_we writes node_count; use it only while the block is idle (the block does not enforce this)
//  - a load is done without leaving idle; the block works on one item at a time
//  - k-th successor query: at most one table read per set bit of
//    step_count, through the single memory read port
//  - distance query: climb then descend
//  - first query after a load or config write first rebuilds every level
//    above level 0, with two or three table accesses per entry
//  - reset clears control state and sets node_count to 1024; the table is
//    not cleared, entries must be loaded before they are walked
//  - when out_tready is low the answer waits in the output register; the
//    next transaction is still taken and worked on until its own answer is
//    ready to be loaded
`timescale 1ns / 1ps
`default_nettype none
module functional_graph_binary_lifting import fgbl_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int STEP_BITS = STEP_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // opcode, node, successor, step_count, lower_bound, upper_bound
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // answer
  output logic [OUT_W-1:0]      out_tdata,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t st;

  // sequencer
  fgbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tdata[1:0]),
    .cfg_we    (cfg_we),
    .in_tready (in_tready),
    .cmd       (cmd),
    .st        (st)
  );

  // table memory and walk registers
  fgbl_dp #(
    .MAX_NODES (MAX_NODES),
    .STEP_BITS (STEP_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_tdata),
    .cmd        (cmd),
    .st         (st)
  );

endmodule
`default_nettype wire
